// ===== rtl/sgrd_pkg.sv =====
// Shared constants and types for the silence gap run detector.
`default_nettype none

package sgrd_pkg;

  // Default sizing.
  localparam int MaxBucketsDef = 1048576;
  localparam int LevelBitsDef  = 12;
  localparam int IdxWDef       = $clog2(MaxBucketsDef + 1);
  localparam int SumWDef       = LevelBitsDef + IdxWDef;

  // Register reset values.
  localparam int SilentRst  = -1440;
  localparam int LoudRst    = -640;
  localparam int MinRunRst  = 20;
  localparam int LoopEndRst = 0;

  // Configuration port sizing.
  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;

  // Register indexes, byte address divided by four.
  typedef enum logic [1:0] {
    REG_SILENT   = 2'd0,
    REG_LOUD     = 2'd1,
    REG_MIN_RUN  = 2'd2,
    REG_LOOP_END = 2'd3
  } reg_idx_e;

  // Top level control states.
  typedef enum logic [0:0] {
    ST_IDLE = 1'b0,
    ST_DIV  = 1'b1
  } ctl_state_e;

endpackage

`default_nettype wire

// ===== rtl/sgrd_cfg.sv =====
// Configuration register file behind the APB-style port.
`default_nettype none

module sgrd_cfg #(
  parameter int LVL_W = sgrd_pkg::LevelBitsDef,
  parameter int IDX_W = sgrd_pkg::IdxWDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [sgrd_pkg::ApbAddrW-1:0] paddr_i,
  input  wire logic [sgrd_pkg::ApbDataW-1:0] pwdata_i,
  output logic      [sgrd_pkg::ApbDataW-1:0] prdata_o,
  output logic                               pready_o,
  output logic      [LVL_W-1:0]              silent_o,
  output logic      [LVL_W-1:0]              loud_o,
  output logic      [IDX_W-1:0]              min_run_o,
  output logic      [IDX_W-1:0]              loop_end_o
);

  logic [LVL_W-1:0] silent_q;
  logic [LVL_W-1:0] loud_q;
  logic [IDX_W-1:0] min_run_q;
  logic [IDX_W-1:0] loop_end_q;
  logic             wr_en;
  sgrd_pkg::reg_idx_e reg_sel;

  assign pready_o = 1'b1;
  assign wr_en    = psel_i & penable_i & pwrite_i;
  assign reg_sel  = sgrd_pkg::reg_idx_e'(paddr_i[3:2]);

  // Register writes on the access phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      silent_q   <= LVL_W'(sgrd_pkg::SilentRst);
      loud_q     <= LVL_W'(sgrd_pkg::LoudRst);
      min_run_q  <= IDX_W'(sgrd_pkg::MinRunRst);
      loop_end_q <= IDX_W'(sgrd_pkg::LoopEndRst);
    end else if (wr_en) begin
      case (reg_sel)
        sgrd_pkg::REG_SILENT:   silent_q   <= pwdata_i[LVL_W-1:0];
        sgrd_pkg::REG_LOUD:     loud_q     <= pwdata_i[LVL_W-1:0];
        sgrd_pkg::REG_MIN_RUN:  min_run_q  <= pwdata_i[IDX_W-1:0];
        sgrd_pkg::REG_LOOP_END: loop_end_q <= pwdata_i[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back; level thresholds are sign extended.
  always_comb begin
    case (reg_sel)
      sgrd_pkg::REG_SILENT:
        prdata_o = {{(sgrd_pkg::ApbDataW-LVL_W){silent_q[LVL_W-1]}}, silent_q};
      sgrd_pkg::REG_LOUD:
        prdata_o = {{(sgrd_pkg::ApbDataW-LVL_W){loud_q[LVL_W-1]}}, loud_q};
      sgrd_pkg::REG_MIN_RUN:  prdata_o = sgrd_pkg::ApbDataW'(min_run_q);
      sgrd_pkg::REG_LOOP_END: prdata_o = sgrd_pkg::ApbDataW'(loop_end_q);
      default:                prdata_o = '0;
    endcase
  end

  assign silent_o   = silent_q;
  assign loud_o     = loud_q;
  assign min_run_o  = min_run_q;
  assign loop_end_o = loop_end_q;

endmodule

`default_nettype wire

// ===== rtl/sgrd_run.sv =====
// Run tracker: qualifies buckets, keeps the open run and decides when a run is reported.
`default_nettype none

module sgrd_run #(
  parameter int MAX_BUCKETS = sgrd_pkg::MaxBucketsDef,
  parameter int LVL_W       = sgrd_pkg::LevelBitsDef,
  parameter int IDX_W       = sgrd_pkg::IdxWDef,
  parameter int SUM_W       = sgrd_pkg::SumWDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             en_i,
  input  wire logic [LVL_W-1:0] built_i,
  input  wire logic [LVL_W-1:0] game_i,
  input  wire logic             last_i,
  input  wire logic [LVL_W-1:0] silent_i,
  input  wire logic [LVL_W-1:0] loud_i,
  input  wire logic [IDX_W-1:0] min_run_i,
  input  wire logic [IDX_W-1:0] loop_end_i,
  output logic                  report_o,
  output logic      [IDX_W-1:0] start_o,
  output logic      [IDX_W-1:0] end_o,
  output logic      [SUM_W-1:0] sum_o,
  output logic      [IDX_W-1:0] len_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             in_run_q, in_run_d;
  logic [IDX_W-1:0] begin_q, begin_d;
  logic [SUM_W-1:0] sum_q, sum_d;

  logic             room;
  logic             qual;
  logic             closing;
  logic [IDX_W-1:0] begin_eff;
  logic [SUM_W-1:0] sum_eff;
  logic [SUM_W-1:0] close_sum;
  logic [IDX_W-1:0] stop;
  logic [IDX_W-1:0] len;
  logic             empty_run;
  logic             too_short;
  logic             loop_on;
  logic             loop_drop;

  // Bucket qualification; past the index limit nothing qualifies.
  assign room = idx_q < IDX_W'(MAX_BUCKETS);
  assign qual = room && ($signed(built_i) <= $signed(silent_i))
                     && ($signed(game_i) >= $signed(loud_i));

  // Open run as it stands with this bucket included.
  assign begin_eff = in_run_q ? begin_q : idx_q;
  assign sum_eff   = (in_run_q ? sum_q : '0) + {{(SUM_W-LVL_W){game_i[LVL_W-1]}}, game_i};
  assign closing   = qual ? last_i : in_run_q;
  assign close_sum = qual ? sum_eff : sum_q;
  assign stop      = qual ? idx_q + IDX_W'(1) : idx_q;

  // Report filters: length, minimum run and loop end.
  assign len       = stop - begin_eff;
  assign empty_run = stop <= begin_eff;
  assign too_short = len < min_run_i;
  assign loop_on   = loop_end_i != '0;
  assign loop_drop = loop_on && (begin_eff >= loop_end_i);

  assign report_o = en_i && closing && !empty_run && !too_short && !loop_drop;
  assign start_o  = begin_eff;
  assign end_o    = (loop_on && (stop > loop_end_i)) ? loop_end_i : stop;
  assign sum_o    = close_sum;
  assign len_o    = len;

  // Next run state.
  always_comb begin
    idx_d    = idx_q;
    in_run_d = in_run_q;
    begin_d  = begin_q;
    sum_d    = sum_q;
    if (en_i) begin
      if (last_i) begin
        idx_d = '0;
      end else if (room) begin
        idx_d = idx_q + IDX_W'(1);
      end
      if (qual && !last_i) begin
        in_run_d = 1'b1;
        begin_d  = begin_eff;
        sum_d    = sum_eff;
      end else begin
        in_run_d = 1'b0;
        begin_d  = '0;
        sum_d    = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      in_run_q <= 1'b0;
      begin_q  <= '0;
      sum_q    <= '0;
    end else begin
      idx_q    <= idx_d;
      in_run_q <= in_run_d;
      begin_q  <= begin_d;
      sum_q    <= sum_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/sgrd_div.sv =====
// Bit-serial restoring divider forming the truncated run mean, one quotient bit per cycle.
`default_nettype none

module sgrd_div #(
  parameter int LVL_W = sgrd_pkg::LevelBitsDef,
  parameter int IDX_W = sgrd_pkg::IdxWDef,
  parameter int SUM_W = sgrd_pkg::SumWDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             ack_i,
  input  wire logic [SUM_W-1:0] dividend_i,
  input  wire logic [IDX_W-1:0] divisor_i,
  output logic                  done_o,
  output logic      [LVL_W-1:0] mean_o
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [IDX_W-1:0] rem_q;
  logic [IDX_W-1:0] dvs_q;
  logic [SUM_W-1:0] dvd_q;
  logic [LVL_W-1:0] quo_q;
  logic             neg_q;

  logic [SUM_W-1:0] dvd_abs;
  logic [IDX_W:0]   trial;
  logic [IDX_W-1:0] diff;
  logic             fits;

  assign dvd_abs = dividend_i[SUM_W-1] ? (~dividend_i + SUM_W'(1)) : dividend_i;

  // One restoring step: bring down the next dividend bit and try the subtract.
  assign trial = {rem_q, dvd_q[SUM_W-1]};
  assign diff  = trial[IDX_W-1:0] - dvs_q;
  assign fits  = trial >= {1'b0, dvs_q};

  // Control of the iteration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(SUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else if (ack_i) begin
      done_q <= 1'b0;
    end
  end

  // Datapath shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_abs;
      dvs_q <= divisor_i;
      neg_q <= dividend_i[SUM_W-1];
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
      rem_q <= fits ? diff : trial[IDX_W-1:0];
      quo_q <= {quo_q[LVL_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign mean_o = neg_q ? (~quo_q + LVL_W'(1)) : quo_q;

endmodule

`default_nettype wire

// ===== rtl/silence_gap_run_detector.sv =====
// Top level: finds silent runs in paired envelope buckets and reports start, end and mean level.
// A bucket that closes a reported run has its mean formed by the bit-serial mean divider, and
// the result is then moved into the output register once that register is free.
// A bucket that reports nothing does not hold the input; a reporting bucket holds the input
// until its mean is handed to the output register, and longer while the output is stalled.
// Reset: asynchronous, active low; registers return to their reset values and the bucket
// index and open run are cleared. No clearing pass is needed.
`default_nettype none

module silence_gap_run_detector #(
  parameter int MAX_BUCKETS = sgrd_pkg::MaxBucketsDef,
  parameter int LEVEL_BITS  = sgrd_pkg::LevelBitsDef,
  localparam int IDX_W = $clog2(MAX_BUCKETS + 1),
  localparam int LVL_W = LEVEL_BITS,
  localparam int SUM_W = LVL_W + IDX_W,
  localparam int IN_W  = ((2 * LVL_W + 7) / 8) * 8,
  localparam int OUT_W = ((2 * IDX_W + LVL_W + 7) / 8) * 8
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Bucket stream; tdata: built_level, game_level. tlast: last_bucket.
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  wire logic [IN_W-1:0]               s_axis_tdata_i,
  input  wire logic                          s_axis_tlast_i,
  // Gap stream; tdata: gap_start, gap_end, gap_mean_level.
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  output logic      [OUT_W-1:0]              m_axis_tdata_o,
  // Configuration port.
  input  wire logic                          psel_i,
  input  wire logic                          penable_i,
  input  wire logic                          pwrite_i,
  input  wire logic [sgrd_pkg::ApbAddrW-1:0] paddr_i,
  input  wire logic [sgrd_pkg::ApbDataW-1:0] pwdata_i,
  output logic      [sgrd_pkg::ApbDataW-1:0] prdata_o,
  output logic                               pready_o
);

  sgrd_pkg::ctl_state_e state_q, state_d;

  logic [LVL_W-1:0] silent;
  logic [LVL_W-1:0] loud;
  logic [IDX_W-1:0] min_run;
  logic [IDX_W-1:0] loop_end;

  logic             in_beat;
  logic             report;
  logic [IDX_W-1:0] run_start;
  logic [IDX_W-1:0] run_end;
  logic [SUM_W-1:0] run_sum;
  logic [IDX_W-1:0] run_len;
  logic             div_start;
  logic             div_done;
  logic [LVL_W-1:0] div_mean;
  logic             ack;

  logic [IDX_W-1:0] hold_start_q;
  logic [IDX_W-1:0] hold_end_q;
  logic             out_valid_q, out_valid_d;
  logic [IDX_W-1:0] out_start_q;
  logic [IDX_W-1:0] out_end_q;
  logic [LVL_W-1:0] out_mean_q;

  sgrd_cfg #(
    .LVL_W (LVL_W),
    .IDX_W (IDX_W)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel_i     (psel_i),
    .penable_i  (penable_i),
    .pwrite_i   (pwrite_i),
    .paddr_i    (paddr_i),
    .pwdata_i   (pwdata_i),
    .prdata_o   (prdata_o),
    .pready_o   (pready_o),
    .silent_o   (silent),
    .loud_o     (loud),
    .min_run_o  (min_run),
    .loop_end_o (loop_end)
  );

  assign in_beat = s_axis_tvalid_i & s_axis_tready_o;

  sgrd_run #(
    .MAX_BUCKETS (MAX_BUCKETS),
    .LVL_W       (LVL_W),
    .IDX_W       (IDX_W),
    .SUM_W       (SUM_W)
  ) u_run (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (in_beat),
    .built_i    (s_axis_tdata_i[LVL_W-1:0]),
    .game_i     (s_axis_tdata_i[2*LVL_W-1:LVL_W]),
    .last_i     (s_axis_tlast_i),
    .silent_i   (silent),
    .loud_i     (loud),
    .min_run_i  (min_run),
    .loop_end_i (loop_end),
    .report_o   (report),
    .start_o    (run_start),
    .end_o      (run_end),
    .sum_o      (run_sum),
    .len_o      (run_len)
  );

  assign div_start = in_beat & report;

  sgrd_div #(
    .LVL_W (LVL_W),
    .IDX_W (IDX_W),
    .SUM_W (SUM_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .ack_i      (ack),
    .dividend_i (run_sum),
    .divisor_i  (run_len),
    .done_o     (div_done),
    .mean_o     (div_mean)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sgrd_pkg::ST_IDLE: if (div_start) state_d = sgrd_pkg::ST_DIV;
      sgrd_pkg::ST_DIV:  if (ack) state_d = sgrd_pkg::ST_IDLE;
      default:           state_d = sgrd_pkg::ST_IDLE;
    endcase
  end

  // State outputs: input ready, and handoff of the mean into the output register.
  always_comb begin
    s_axis_tready_o = 1'b0;
    ack             = 1'b0;
    case (state_q)
      sgrd_pkg::ST_IDLE: s_axis_tready_o = 1'b1;
      sgrd_pkg::ST_DIV:  ack = div_done & (~out_valid_q | m_axis_tready_i);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sgrd_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Run bounds wait here while the mean is formed.
  always_ff @(posedge clk_i) begin
    if (div_start) begin
      hold_start_q <= run_start;
      hold_end_q   <= run_end;
    end
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    if (ack) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack) begin
      out_start_q <= hold_start_q;
      out_end_q   <= hold_end_q;
      out_mean_q  <= div_mean;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_W'({out_mean_q, out_end_q, out_start_q});

  // A freshly started division is never reported as finished in the next cycle.
  a_div_not_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (state_q == sgrd_pkg::ST_DIV) && !div_done)
    else $error("divider finished right after start");

  // A finished mean only exists while a result is pending.
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == sgrd_pkg::ST_DIV)
    else $error("divider done outside of the divide state");

  // A new result appears only from a completed division.
  a_valid_from_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(state_q) == sgrd_pkg::ST_DIV && $past(div_done))
    else $error("result raised without a finished division");

  // A stalled output keeps the pending result waiting in the divider.
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i && state_q == sgrd_pkg::ST_DIV && div_done)
      |=> state_q == sgrd_pkg::ST_DIV && div_done)
    else $error("pending result lost under output stall");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
// Testbench for the silence gap run detector: streams envelope buckets and checks each gap report.
`timescale 1ns / 1ps

module tb_top;

  localparam int IdxW        = $clog2(sgrd_pkg::MaxBucketsDef + 1);
  localparam int LvlW        = sgrd_pkg::LevelBitsDef;
  localparam int AddrW       = sgrd_pkg::ApbAddrW;
  localparam int DataW       = sgrd_pkg::ApbDataW;
  localparam int InW         = ((2 * LvlW + 7) / 8) * 8;
  localparam int OutW        = ((2 * IdxW + LvlW + 7) / 8) * 8;
  localparam int DrainCycles = 48;
  localparam int HoldCycles  = 300;
  localparam int StallLimit  = 4000;

  // One gap report, gap_start in the lowest bits as on the output stream.
  typedef struct packed {
    logic [LvlW-1:0] gap_mean;
    logic [IdxW-1:0] gap_end;
    logic [IdxW-1:0] gap_start;
  } gap_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [InW-1:0]   s_tdata  = '0;
  logic             s_tlast  = 1'b0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OutW-1:0]  m_tdata;
  logic             psel     = 1'b0;
  logic             penable  = 1'b0;
  logic             pwrite   = 1'b0;
  logic [AddrW-1:0] paddr    = '0;
  logic [DataW-1:0] pwdata   = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Register mirror, kept in step with every configuration write.
  int cfg_silent   = sgrd_pkg::SilentRst;
  int cfg_loud     = sgrd_pkg::LoudRst;
  int cfg_min_run  = sgrd_pkg::MinRunRst;
  int cfg_loop_end = sgrd_pkg::LoopEndRst;

  // Mirror of the detector's running state.
  int     bkt_idx  = 0;
  bit     run_open = 1'b0;
  int     run_head = 0;
  longint run_sum  = 0;

  gap_t predicted_gaps[$];

  bit src_idle_en   = 1'b1;
  bit sink_idle_en  = 1'b1;
  bit sink_hold_req = 1'b0;

  int n_errors     = 0;
  int n_buckets    = 0;
  int n_gaps       = 0;
  int n_settings   = 0;
  int n_holds      = 0;
  int stall_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  silence_gap_run_detector u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // built_level, game_level
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),   // gap_start, gap_end, gap_mean_level
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata),
    .pready_o        (pready)
  );

  // Closes the open run at index stop and decides whether it is reported.
  function automatic bit close_gap(input int stop, output gap_t gap);
    int     head;
    int     run_len;
    int     tail;
    longint total;
    longint mean;
    head     = run_head;
    total    = run_sum;
    run_len  = stop - head;
    tail     = stop;
    run_open = 1'b0;
    run_head = 0;
    run_sum  = 0;
    gap      = '0;
    if (stop <= head || run_len < cfg_min_run) return 1'b0;
    if (cfg_loop_end != 0) begin
      if (head >= cfg_loop_end) return 1'b0;
      if (tail > cfg_loop_end) tail = cfg_loop_end;
    end
    mean          = total / run_len;
    gap.gap_start = head[IdxW-1:0];
    gap.gap_end   = tail[IdxW-1:0];
    gap.gap_mean  = mean[LvlW-1:0];
    return 1'b1;
  endfunction

  // Advances the mirror by one bucket; returns 1 when a gap report is due.
  function automatic bit track_bucket(input logic signed [LvlW-1:0] built,
                                      input logic signed [LvlW-1:0] game,
                                      input bit is_last, output gap_t gap);
    bit room;
    bit found;
    found = 1'b0;
    gap   = '0;
    room  = bkt_idx < sgrd_pkg::MaxBucketsDef;
    if (room && built <= cfg_silent && game >= cfg_loud) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_head = bkt_idx;
        run_sum  = 0;
      end
      run_sum += game;
      if (is_last) found = close_gap(bkt_idx + 1, gap);
    end else if (run_open) begin
      found = close_gap(bkt_idx, gap);
    end
    if (room) bkt_idx++;
    if (is_last) begin
      bkt_idx  = 0;
      run_open = 1'b0;
      run_head = 0;
      run_sum  = 0;
    end
    return found;
  endfunction

  // Mostly short pauses, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(15, 0);
    if (r < 11) return $urandom_range(3, 1);
    if (r < 15) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic logic signed [LvlW-1:0] level_in(input int lo, input int hi);
    return LvlW'(lo + int'($urandom_range(hi - lo, 0)));
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Prediction on accepted buckets, comparison on accepted reports, and the watchdog.
  always @(posedge clk) begin : scoreboard
    gap_t want;
    gap_t got;
    if (rst_n) begin
      if (s_tvalid && s_tready) begin
        n_buckets++;
        if (track_bucket(s_tdata[LvlW-1:0], s_tdata[2*LvlW-1:LvlW], s_tlast, want))
          predicted_gaps.insert(predicted_gaps.size(), want);
      end
      if (m_tvalid && m_tready) begin
        got = gap_t'(m_tdata[2*IdxW+LvlW-1:0]);
        if (predicted_gaps.size() == 0) begin
          n_errors++;
          $display("%0t ns: gap report with none expected, actual start %0d end %0d mean %0d",
                   $time, got.gap_start, got.gap_end, $signed(got.gap_mean));
        end else begin
          want = predicted_gaps.pop_front();
          n_gaps++;
          check_field("gap_start", want.gap_start, got.gap_start);
          check_field("gap_end", want.gap_end, got.gap_end);
          check_field("gap_mean_level", $signed(want.gap_mean), $signed(got.gap_mean));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("%0t ns: no beat moved for %0d cycles", $time, StallLimit);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Report side: random stalls, or one long hold-off on request.
  initial begin : report_sink
    @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        sink_hold_req = 1'b0;
        n_holds++;
      end else if (sink_idle_en && $urandom_range(3, 0) == 0) begin
        m_tready <= 1'b0;
        repeat (idle_len()) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offers one bucket and returns at the edge that accepts it, maybe pausing afterwards.
  task automatic send_bucket(input logic signed [LvlW-1:0] built,
                             input logic signed [LvlW-1:0] game, input bit is_last);
    s_tdata  <= {game, built};
    s_tlast  <= is_last;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (src_idle_en && $urandom_range(4, 0) == 0) begin
      s_tvalid <= 1'b0;
      repeat (idle_len()) @(posedge clk);
    end
  endtask

  // A bucket that qualifies under the current thresholds.
  task automatic send_quiet(input bit is_last);
    send_bucket(level_in(-2048, cfg_silent), level_in(cfg_loud, 2047), is_last);
  endtask

  // A bucket that fails, on the built level or the game level; a qualifying one if no level can fail.
  task automatic send_active(input bit is_last);
    if (cfg_silent < 2047 && (cfg_loud == -2048 || $urandom_range(1, 0) == 1))
      send_bucket(level_in(cfg_silent + 1, 2047), level_in(-2048, 2047), is_last);
    else if (cfg_loud > -2048)
      send_bucket(level_in(-2048, 2047), level_in(-2048, cfg_loud - 1), is_last);
    else
      send_quiet(is_last);
  endtask

  task automatic send_noise(input bit is_last);
    send_bucket(LvlW'($urandom), LvlW'($urandom), is_last);
  endtask

  // One envelope of alternating quiet and active stretches, the final bucket marked last.
  task automatic send_envelope(input int len, input int noise_pct);
    int left;
    int seg;
    bit quiet;
    left  = len;
    quiet = $urandom_range(1, 0);
    while (left > 0) begin
      seg = quiet ? $urandom_range(12, 1) : $urandom_range(3, 1);
      if (seg > left) seg = left;
      repeat (seg) begin
        left--;
        if ($urandom_range(99, 0) < noise_pct) send_noise(left == 0);
        else if (quiet) send_quiet(left == 0);
        else send_active(left == 0);
      end
      quiet = !quiet;
    end
  endtask

  // Stops offering buckets and waits until every predicted report has come out.
  task automatic drain_gaps();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (predicted_gaps.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic apb_write(input sgrd_pkg::reg_idx_e idx, input logic [DataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      sgrd_pkg::REG_SILENT:   cfg_silent = int'($signed(val[LvlW-1:0]));
      sgrd_pkg::REG_LOUD:     cfg_loud = int'($signed(val[LvlW-1:0]));
      sgrd_pkg::REG_MIN_RUN:  cfg_min_run = int'(val[IdxW-1:0]);
      sgrd_pkg::REG_LOOP_END: cfg_loop_end = int'(val[IdxW-1:0]);
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_config(input int silent, input int loud, input int min_run,
                            input int loop_end);
    apb_write(sgrd_pkg::REG_SILENT, DataW'(silent));
    apb_write(sgrd_pkg::REG_LOUD, DataW'(loud));
    apb_write(sgrd_pkg::REG_MIN_RUN, DataW'(min_run));
    apb_write(sgrd_pkg::REG_LOOP_END, DataW'(loop_end));
    n_settings++;
  endtask

  // Reset thresholds: a run of exactly the minimum length is kept, one shorter is not.
  task automatic test_reset_defaults();
    for (int k = 0; k < 20; k++) send_quiet(k == 19);
    for (int k = 0; k < 19; k++) send_quiet(k == 18);
    drain_gaps();
  endtask

  // Field extremes, threshold edges and truncation of a negative mean.
  task automatic test_directed();
    set_config(0, -100, 1, 0);
    send_bucket(-2048, 2047, 1'b0);
    send_bucket(0, -100, 1'b0);
    send_bucket(1, 0, 1'b0);
    send_bucket(0, -101, 1'b0);
    send_bucket(2047, -2048, 1'b0);
    send_bucket(-5, -3, 1'b0);
    send_bucket(-5, -2, 1'b0);
    send_bucket(-2048, -2048, 1'b0);
    send_bucket(-1, 5, 1'b1);
    send_bucket(3, 3, 1'b1);
    send_bucket(-1, -1, 1'b0);
    send_bucket(-1, -1, 1'b0);
    send_bucket(-1, 1, 1'b1);
    send_bucket(-2048, 2047, 1'b1);
    drain_gaps();
  endtask

  // Zero minimum reports a single bucket; with a minimum of three, shorter runs vanish.
  task automatic test_run_length();
    set_config(-200, -300, 0, 0);
    send_quiet(1'b1);
    send_active(1'b0);
    send_quiet(1'b0);
    send_active(1'b1);
    drain_gaps();
    set_config(-200, -300, 3, 0);
    repeat (2) send_quiet(1'b0);
    send_active(1'b0);
    repeat (3) send_quiet(1'b0);
    send_active(1'b0);
    repeat (2) send_quiet(1'b0);
    send_quiet(1'b1);
    drain_gaps();
  endtask

  // Loop end: runs past it are clipped, runs starting at or after it are dropped.
  task automatic test_loop_clip();
    set_config(100, 0, 1, 5);
    repeat (2) send_active(1'b0);
    repeat (7) send_quiet(1'b0);
    send_active(1'b1);
    repeat (5) send_active(1'b0);
    repeat (2) send_quiet(1'b0);
    send_active(1'b1);
    repeat (5) send_quiet(1'b0);
    send_active(1'b1);
    repeat (6) send_active(1'b0);
    send_quiet(1'b0);
    send_quiet(1'b1);
    drain_gaps();
    set_config(100, 0, 1, 1);
    repeat (3) send_quiet(1'b0);
    send_active(1'b1);
    drain_gaps();
  endtask

  // Register extremes: tightest and loosest thresholds, largest minimum and loop end.
  task automatic test_config_extremes();
    set_config(-2048, 2047, 1, 2097151);
    send_envelope(12, 0);
    drain_gaps();
    set_config(2047, -2048, 2097151, 1048576);
    send_envelope(10, 20);
    drain_gaps();
    set_config(2047, -2048, 1048576, 0);
    send_envelope(8, 50);
    drain_gaps();
    set_config(2047, -2048, 1, 1048576);
    send_envelope(9, 30);
    drain_gaps();
  endtask

  // Output held off so the detector backs up, then the input paused inside an envelope.
  task automatic test_backpressure();
    int len;
    set_config(2047, -2048, 1, 0);
    sink_hold_req = 1'b1;
    repeat (12) begin
      len = $urandom_range(3, 1);
      for (int k = 0; k < len; k++) send_quiet(k == len - 1);
    end
    drain_gaps();
    set_config(0, 0, 2, 0);
    repeat (4) send_quiet(1'b0);
    send_active(1'b0);
    drain_gaps();
    repeat (3) send_quiet(1'b0);
    send_active(1'b1);
    drain_gaps();
  endtask

  // Random envelopes under random settings, with every mix of idling on the two sides.
  task automatic test_random();
    int sent;
    int len;
    for (int phase = 0; phase < 4; phase++) begin
      set_config(int'($urandom_range(4095, 0)) - 2048, int'($urandom_range(4095, 0)) - 2048,
                 $urandom_range(6, 1), $urandom_range(1, 0) ? 0 : $urandom_range(40, 1));
      src_idle_en  = phase[0];
      sink_idle_en = phase[1];
      sent = 0;
      while (sent < 40) begin
        len = $urandom_range(40, 4);
        send_envelope(len, 15);
        sent += len;
      end
      drain_gaps();
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  initial begin : test_sequence
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_directed();
    test_run_length();
    test_loop_clip();
    test_config_extremes();
    test_backpressure();
    test_random();
    drain_gaps();
    $display("Checked %0d gap reports from %0d buckets under %0d register settings.",
             n_gaps, n_buckets, n_settings);
    $display("Covered threshold edges, short and clipped runs and %0d long output hold-offs.",
             n_holds);
    if (n_errors == 0 && predicted_gaps.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule

// ===== silence_gap_run_detector.f =====
rtl/sgrd_pkg.sv
rtl/sgrd_cfg.sv
rtl/sgrd_run.sv
rtl/sgrd_div.sv
rtl/silence_gap_run_detector.sv
bench/tb_top.sv
